FILE: hw/rtl/pwmc_pkg.sv
// Shared types and constants for the PWM period/duty capture block.
// No dependencies.
package pwmc_pkg;

  localparam int TS_W     = 16;
  localparam int CLK_HZ_W = 27;
  localparam int PRE_W    = 11;
  localparam int FREQ_W   = 16;
  localparam int DUTY_W   = 7;
  localparam int PCT_W    = 7;

  localparam logic [CLK_HZ_W-1:0] CLOCK_HZ_RST = 27'd16000000;
  localparam logic [PRE_W-1:0]    PRESCALER_RST = 11'd1024;
  localparam logic [PCT_W-1:0]    PCT           = 7'd100;
  localparam logic [FREQ_W-1:0]   FREQ_MAX      = 16'hFFFF;
  localparam logic [DUTY_W-1:0]   DUTY_MAX      = 7'd100;

  localparam logic OP_START = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  localparam logic REG_CLOCK_HZ  = 1'b0;
  localparam logic REG_PRESCALER = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_FALL   = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_FDIV,
    S_DDIV,
    S_DONE
  } seq_state_t;

endpackage

FILE: hw/rtl/pwm_period_duty_capture.sv
// PWM capture: start and edge words go in; after the falling edge one result word
// comes out with period, high time, frequency and duty. Start words and edge
// words that do not end a measurement are taken whenever the block is idle. The
// word that ends one starts the sequence: period and high time, the high*100
// product, then one shared one-bit-per-cycle divider run twice:
// clock_hz/(prescaler*period), a zero prescaler counting as 1, then
// high*100/period. A zero period skips both divides. No new word is taken while
// that runs, nor while a finished result waits for out_ready. Uses pwmc_pkg, pwmc_div.
module pwm_period_duty_capture
  import pwmc_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CLK_HZ_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [TS_W-1:0]     timestamp,
  input  logic                edge_rising,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TS_W-1:0]     period_ticks,
  output logic [TS_W-1:0]     high_ticks,
  output logic [FREQ_W-1:0]   frequency_hz,
  output logic [DUTY_W-1:0]   duty_percent,
  output logic                zero_period
);

  localparam int CB    = COUNTER_BITS;
  localparam int HI_W  = CB + PCT_W;
  localparam int DVD_W = (HI_W > CLK_HZ_W) ? HI_W : CLK_HZ_W;
  localparam int DVS_W = CB + PRE_W;

  logic [CLK_HZ_W-1:0] clock_hz;
  logic [PRE_W-1:0]    prescaler;

  phase_t     phase, phase_next;
  seq_state_t state, state_next;

  logic [CB-1:0] first_rise, second_rise, fall_time;
  logic [CB-1:0] ts_c;
  logic          in_acc;
  logic          cap_first, cap_second, cap_fall;

  logic [CB-1:0]    period, high;
  logic             zero;
  logic [HI_W-1:0]  hi100;
  logic [PRE_W-1:0] pre_eff;
  logic [DVS_W-1:0] denom_c;
  logic [HI_W-1:0]  hi100_c;
  logic [FREQ_W-1:0] freq;
  logic [DUTY_W-1:0] duty;

  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quot;
  logic             load_out;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz  <= CLOCK_HZ_RST;
      prescaler <= PRESCALER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLOCK_HZ:  clock_hz  <= cfg_data;
        REG_PRESCALER: prescaler <= cfg_data[PRE_W-1:0];
        default: ;
      endcase
    end
  end

  // edge tracking
  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign ts_c     = CB'(timestamp);

  always_comb begin
    phase_next = phase;
    cap_first  = 1'b0;
    cap_second = 1'b0;
    cap_fall   = 1'b0;
    if (in_acc) begin
      if (opcode == OP_START) begin
        phase_next = PH_FIRST;
      end else begin
        case (phase)
          PH_FIRST: begin
            if (edge_rising) begin
              cap_first  = 1'b1;
              phase_next = PH_SECOND;
            end
          end
          PH_SECOND: begin
            if (edge_rising) begin
              cap_second = 1'b1;
              phase_next = PH_FALL;
            end
          end
          PH_FALL: begin
            if (!edge_rising) begin
              cap_fall   = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      first_rise  <= '0;
      second_rise <= '0;
      fall_time   <= '0;
    end else begin
      phase <= phase_next;
      if (cap_first)  first_rise  <= ts_c;
      if (cap_second) second_rise <= ts_c;
      if (cap_fall)   fall_time   <= ts_c;
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cap_fall) state_next = S_PREP;
      S_PREP: state_next = S_MUL;
      S_MUL:  state_next = zero ? S_DONE : S_FDIV;
      S_FDIV: if (div_done) state_next = S_DDIV;
      S_DDIV: if (div_done) state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DVD_W'(clock_hz);
    div_divisor  = denom_c;
    load_out     = 1'b0;
    case (state)
      S_MUL: div_start = !zero;
      S_FDIV: begin
        div_start    = div_done;
        div_dividend = DVD_W'(hi100);
        div_divisor  = DVS_W'(period);
      end
      S_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // datapath
  assign pre_eff = (prescaler == '0) ? PRE_W'(1) : prescaler;
  assign denom_c = DVS_W'(pre_eff) * DVS_W'(period);
  assign hi100_c = HI_W'(high) * HI_W'(PCT);

  always_ff @(posedge clk) begin
    case (state)
      S_PREP: begin
        period <= second_rise - first_rise;
        high   <= fall_time - second_rise;
        zero   <= (second_rise == first_rise);
      end
      S_MUL: begin
        hi100 <= hi100_c;
        if (zero) begin
          freq <= '0;
          duty <= '0;
        end
      end
      S_FDIV: begin
        if (div_done)
          freq <= (div_quot > DVD_W'(FREQ_MAX)) ? FREQ_MAX : div_quot[FREQ_W-1:0];
      end
      S_DDIV: begin
        if (div_done)
          duty <= (div_quot > DVD_W'(DUTY_MAX)) ? DUTY_MAX : div_quot[DUTY_W-1:0];
      end
      default: ;
    endcase
  end

  pwmc_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      period_ticks <= TS_W'(period);
      high_ticks   <= TS_W'(high);
      frequency_hz <= freq;
      duty_percent <= duty;
      zero_period  <= zero;
    end
  end

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_percent <= DUTY_MAX))
    else $error("duty above 100");

  a_zero_results: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_period) |-> (frequency_hz == '0 && duty_percent == '0))
    else $error("zero period with nonzero results");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_FDIV || state == S_DDIV))
    else $error("divider finished outside a divide step");

  a_fall_starts_seq: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == OP_EDGE && !edge_rising && phase == PH_FALL)
      |=> (state == S_PREP && phase == PH_IDLE))
    else $error("falling edge did not start the computation");

endmodule

FILE: hw/rtl/pwmc_div.sv
// Restoring divider, one quotient bit per cycle, shared by frequency and duty.
// Depends on nothing; widths come from parameters.
module pwmc_div #(
  parameter int DVD_W = 27,
  parameter int DVS_W = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] dvd;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             qbit;

  always_comb begin
    shifted = {rem, dvd[DVD_W-1]};
    diff    = shifted - {1'b0, dvs};
    qbit    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], qbit};
    end
  end

  assign quotient = dvd;

endmodule

FILE: dv/pwm_period_duty_capture_test.sv
// Testbench for pwm_period_duty_capture: drives start and edge words, predicts each
// period/high/frequency/duty result and checks it. Depends on pwmc_pkg and the RTL.
module pwm_period_duty_capture_test
  import pwmc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = 80;
  localparam int N_DIR       = 24;
  localparam int N_PHASES    = 6;
  localparam int PHASE_WORDS = 322;

  typedef struct packed {
    logic [TS_W-1:0]   period;
    logic [TS_W-1:0]   high;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    logic              zero;
  } capture_t;

  typedef struct {
    logic            op;
    logic [TS_W-1:0] ts;
    logic            rise;
    bit              typed;
    capture_t        res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_CLOCK_HZ;
  logic [CLK_HZ_W-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                opcode = OP_START;
  logic [TS_W-1:0]     timestamp = '0;
  logic                edge_rising = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [TS_W-1:0]     period_ticks;
  logic [TS_W-1:0]     high_ticks;
  logic [FREQ_W-1:0]   frequency_hz;
  logic [DUTY_W-1:0]   duty_percent;
  logic                zero_period;

  pwm_period_duty_capture DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [CLK_HZ_W-1:0] cur_clock_hz = CLOCK_HZ_RST;
  logic [PRE_W-1:0]    cur_prescaler = PRESCALER_RST;
  phase_t              meas_phase = PH_IDLE;
  logic [TS_W-1:0]     first_rise = '0;
  logic [TS_W-1:0]     second_rise = '0;

  capture_t pending_captures[$];
  int       live_words = 0;
  int       mismatches = 0;
  int       cycles = 0;
  int       in_calm = 0;
  int       out_calm = 0;
  int       out_hold = 0;

  // ts: 0 and 65535 extremes; wrong polarity, restart and idle edges included
  stim_row_t directed_rows [N_DIR] = '{
    '{OP_EDGE,  16'd100,   1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd200,   1'b0, 1'b0, '0},
    '{OP_START, 16'd0,     1'b0, 1'b0, '0},
    '{OP_EDGE,  16'd5,     1'b0, 1'b0, '0},
    '{OP_EDGE,  16'd0,     1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd9,     1'b0, 1'b0, '0},
    '{OP_EDGE,  16'd0,     1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd7,     1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd65535, 1'b0, 1'b1, '{16'd0, 16'd65535, 16'd0, 7'd0, 1'b1}},
    '{OP_EDGE,  16'd1,     1'b1, 1'b0, '0},
    '{OP_START, 16'd65535, 1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd65535, 1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd0,     1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd3,     1'b0, 1'b1, '{16'd1, 16'd3, 16'd15625, 7'd100, 1'b0}},
    '{OP_START, 16'd0,     1'b0, 1'b0, '0},
    '{OP_EDGE,  16'd0,     1'b1, 1'b0, '0},
    '{OP_START, 16'd0,     1'b0, 1'b0, '0},
    '{OP_EDGE,  16'd0,     1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd65535, 1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd65535, 1'b0, 1'b1, '{16'd65535, 16'd0, 16'd0, 7'd0, 1'b0}},
    '{OP_START, 16'd0,     1'b0, 1'b0, '0},
    '{OP_EDGE,  16'd1000,  1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd1400,  1'b1, 1'b0, '0},
    '{OP_EDGE,  16'd1500,  1'b0, 1'b0, '0}
  };

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic capture_t measure_pwm(logic [TS_W-1:0] r1, logic [TS_W-1:0] r2,
                                           logic [TS_W-1:0] fall);
    capture_t   res;
    logic [63:0] pre;
    logic [63:0] quo;
    logic [63:0] pct;
    res = '0;
    res.period = r2 - r1;
    res.high = fall - r2;
    if (res.period == '0) begin
      res.zero = 1'b1;
    end else begin
      pre = (cur_prescaler == '0) ? 64'd1 : 64'(cur_prescaler);
      quo = 64'(cur_clock_hz) / (pre * 64'(res.period));
      res.freq = (quo > 64'(FREQ_MAX)) ? FREQ_MAX : quo[FREQ_W-1:0];
      pct = (64'(res.high) * 64'(PCT)) / 64'(res.period);
      res.duty = (pct > 64'(DUTY_MAX)) ? DUTY_MAX : pct[DUTY_W-1:0];
    end
    return res;
  endfunction

  task automatic send_word(input logic op, input logic [TS_W-1:0] ts, input logic rise,
                           input bit typed = 1'b0, input capture_t typed_res = '0);
    int       gap;
    capture_t res;
    in_valid <= 1'b1;
    opcode <= op;
    timestamp <= ts;
    edge_rising <= rise;
    do @(posedge clk); while (!in_ready);
    live_words++;
    if (op == OP_START) begin
      meas_phase = PH_FIRST;
    end else begin
      case (meas_phase)
        PH_FIRST: if (rise) begin
          first_rise = ts;
          meas_phase = PH_SECOND;
        end
        PH_SECOND: if (rise) begin
          second_rise = ts;
          meas_phase = PH_FALL;
        end
        PH_FALL: if (!rise) begin
          res = measure_pwm(first_rise, second_rise, ts);
          pending_captures.push_back(typed ? typed_res : res);
          meas_phase = PH_IDLE;
        end
        default: ;
      endcase
    end
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_captures.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CLK_HZ_W-1:0] hz, input logic [PRE_W-1:0] pre);
    cfg_we <= 1'b1;
    cfg_index <= REG_CLOCK_HZ;
    cfg_data <= hz;
    @(posedge clk);
    cur_clock_hz = hz;
    cfg_index <= REG_PRESCALER;
    cfg_data <= CLK_HZ_W'(pre);
    @(posedge clk);
    cur_prescaler = pre;
    cfg_we <= 1'b0;
  endtask

  task automatic noise_word();
    send_word(($urandom_range(0, 3) == 0) ? OP_START : OP_EDGE, 16'($urandom),
              1'($urandom));
  endtask

  task automatic run_measurement();
    logic [TS_W-1:0] r1;
    logic [TS_W-1:0] per;
    logic [TS_W-1:0] hi;
    r1 = 16'($urandom);
    case ($urandom_range(0, 15))
      0: per = '0;
      1, 2, 3, 4: per = 16'($urandom_range(1, 40));
      5: per = 16'hFFFF;
      default: per = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: hi = '0;
      1: hi = per;
      2: hi = 16'($urandom);
      default: hi = (per == '0) ? 16'($urandom) : 16'($urandom_range(0, per - 1));
    endcase
    send_word(OP_START, 16'($urandom), 1'($urandom));
    if ($urandom_range(0, 7) == 0) send_word(OP_EDGE, 16'($urandom), 1'b0);
    send_word(OP_EDGE, r1, 1'b1);
    if ($urandom_range(0, 19) == 0) begin
      send_word(OP_START, 16'($urandom), 1'($urandom));
      send_word(OP_EDGE, r1, 1'b1);
    end
    if ($urandom_range(0, 7) == 0) send_word(OP_EDGE, 16'($urandom), 1'b0);
    send_word(OP_EDGE, r1 + per, 1'b1);
    if ($urandom_range(0, 7) == 0) send_word(OP_EDGE, 16'($urandom), 1'b1);
    send_word(OP_EDGE, r1 + per + hi, 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_hold <= pick_gap(out_calm);
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    capture_t got;
    capture_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{period_ticks, high_ticks, frequency_hz, duty_percent, zero_period};
      if (pending_captures.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: period %0d high %0d freq %0d duty %0d zero %0d",
                   got.period, got.high, got.freq, got.duty, got.zero);
      end else begin
        want = pending_captures.pop_front();
        if (got.period !== want.period || got.high !== want.high ||
            got.freq !== want.freq || got.duty !== want.duty || got.zero !== want.zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp period %0d high %0d freq %0d duty %0d zero %0d, got %0d %0d %0d %0d %0d",
                     want.period, want.high, want.freq, want.duty, want.zero,
                     got.period, got.high, got.freq, got.duty, got.zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [CLK_HZ_W-1:0] hz_set [N_PHASES];
    logic [PRE_W-1:0]    pre_set [N_PHASES];
    int                  target;
    hz_set = '{27'd100000000, 27'd1, 27'd16000000,
               27'($urandom_range(1, 100000000)), 27'd100000000,
               27'($urandom_range(1, 100000000))};
    pre_set = '{11'd1, 11'd1024, 11'd0, 11'($urandom_range(1, 1024)), 11'd1024,
                11'($urandom_range(1, 1024))};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].ts, directed_rows[i].rise,
                directed_rows[i].typed, directed_rows[i].res);
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_regs(hz_set[p], pre_set[p]);
      target = live_words + PHASE_WORDS;
      while (live_words < target) begin
        if ($urandom_range(0, 9) < 8) run_measurement();
        else noise_word();
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
